// ===== sv/bsfc_pkg.sv =====
// Package for the bitmap set/find/count block.
// Holds field widths, request kind codes, payload types and the byte helpers.
// No dependencies.
package bsfc_pkg;

    // Field widths fixed by the external interface.
    localparam int KIND_W = 2;
    localparam int OFF_W  = 10;
    localparam int CNT_W  = 11;

    // Default geometry and register reset value.
    localparam int MAX_BITS_DEF = 1024;
    localparam logic [CNT_W-1:0] BIT_COUNT_RST = 11'd1024;

    // Byte-level constants.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam int BYTE_BITS = 8;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  bit_offset;
    } req_t;

    typedef struct packed {
        logic             bit_value;
        logic             out_of_range;
        logic [CNT_W-1:0] ones_count;
        logic             any_set;
        logic [CNT_W-1:0] lowest_set;
        logic [CNT_W-1:0] lowest_clear;
    } rsp_t;

    // Number of set bits in one byte.
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < BYTE_BITS; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    // Index of the lowest set bit of a byte; zero when the byte is empty.
    function automatic logic [2:0] low8(input logic [7:0] v);
        logic [2:0] p;
        p = 3'd0;
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== sv/bsfc_if.sv =====
// Request and response channel interfaces for the bitmap set/find/count block.
// Each carries valid, ready and a payload struct. Depends on bsfc_pkg.
interface bsfc_req_if;
    import bsfc_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bsfc_rsp_if;
    import bsfc_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/bitmap_set_find_count_top.sv =====
// Top level of the bitmap set/find/count block: bitmap memory, sequencer and scan unit.
// Depends on bsfc_pkg and the channel interfaces in bsfc_if.sv.
//
// A byte-organized bitmap, cleared at reset, that serves one request at a time. Each request
// gets or changes one bit and then a single scan unit walks the bitmap memory one byte per
// cycle, building the population count and the lowest set and clear positions. A request
// passes through a read-modify-write state and then a scan state that walks ceil(n/8) bytes,
// where n is the bit count in use, paced by the memory's single registered read port. A
// waiting response sits in an output register, so a new request can start while it is not
// yet taken; if that response is still waiting when the next scan ends, the block holds the
// new result and takes no request until the output register frees up.
module bitmap_set_find_count_top #(
    parameter int MAX_BITS = bsfc_pkg::MAX_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bsfc_pkg::CNT_W-1:0] cfg_wr_data,
    bsfc_req_if.sink                   req,
    bsfc_rsp_if.source                 rsp
);
    import bsfc_pkg::*;

    // Geometry. Offsets stay below 1024 and bit counts below 2048, so at most
    // 256 bytes are ever scanned.
    localparam int MAP_BYTES  = (MAX_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int USED_BYTES = (MAP_BYTES < 256) ? MAP_BYTES : 256;
    localparam int AW         = (USED_BYTES > 1) ? $clog2(USED_BYTES) : 1;
    localparam int IW         = $clog2(USED_BYTES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RMW  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  bit_count_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [AW-1:0]     byte_idx_reg;
    logic [2:0]        bit_sel_reg;
    logic              oor_reg;
    logic              prior_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [IW-1:0]     nbytes_reg;
    logic [IW-1:0]     idx_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_idx_reg;
    logic [CNT_W-1:0]  ones_reg;
    logic              fset_reg;
    logic              fclr_reg;
    logic [CNT_W-1:0]  lset_reg;
    logic [CNT_W-1:0]  lclr_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [7:0]        mem [USED_BYTES];
    logic              vld_reg [USED_BYTES];
    logic [7:0]        rd_byte_reg;

    logic              req_acc;
    logic [CNT_W-1:0]  n_sat;
    logic [CNT_W:0]    nbytes_sum;
    logic              acc_oor;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [7:0]        wr_byte;
    logic [7:0]        bit_mask;
    logic              scan_issue;
    logic              scan_end;
    logic              out_free;
    logic [CNT_W-1:0]  pos_set;
    logic [CNT_W-1:0]  pos_clr;
    logic [7:0]        inv_byte;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    // Bit count in use, saturated at the bitmap size, and the bytes covering it.
    assign n_sat = ({21'd0, bit_count_reg} > 32'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bit_count_reg;
    assign nbytes_sum = {1'b0, n_sat} + (CNT_W + 1)'(BYTE_BITS - 1);
    assign acc_oor = (req.payload.kind != KIND_QUERY) &&
                     ({1'b0, req.payload.bit_offset} >= n_sat);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bit_count_reg <= BIT_COUNT_RST;
        end else if (cfg_wr_en) begin
            bit_count_reg <= cfg_wr_data;
        end
    end

    // Memory read address: the addressed byte at acceptance, the scan pointer afterwards.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_addr = AW'(req.payload.bit_offset >> 3);
        end else begin
            rd_addr = AW'(idx_reg);
        end
    end

    // Read-modify-write of the addressed byte.
    assign bit_mask = 8'(1) << bit_sel_reg;
    assign wr_en = (state_reg == ST_RMW) && !oor_reg &&
                   ((kind_reg == KIND_SET) || (kind_reg == KIND_CLR));
    assign wr_byte = (kind_reg == KIND_SET) ? (rd_byte_reg | bit_mask)
                                            : (rd_byte_reg & ~bit_mask);

    // Bitmap memory with a registered read; unwritten bytes read as zero.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[byte_idx_reg] <= wr_byte;
        end
        rd_byte_reg <= vld_reg[rd_addr] ? mem[rd_addr] : BYTE_ZERO;
    end

    // Per-byte written flags, cleared at reset.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < USED_BYTES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (wr_en) begin
            vld_reg[byte_idx_reg] <= 1'b1;
        end
    end

    // Scan control and candidate positions of the byte now in the read register.
    assign scan_issue = (idx_reg < nbytes_reg);
    assign scan_end   = !scan_issue && !pend_reg;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign inv_byte   = ~rd_byte_reg;
    assign pos_set    = CNT_W'({pend_idx_reg, low8(rd_byte_reg)});
    assign pos_clr    = CNT_W'({pend_idx_reg, low8(inv_byte)});

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_acc) begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_end && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN) && scan_issue;
        end
    end

    // Request capture, bit read and scan accumulation.
    always_ff @(posedge clk) begin
        if (req_acc) begin
            kind_reg     <= req.payload.kind;
            byte_idx_reg <= AW'(req.payload.bit_offset >> 3);
            bit_sel_reg  <= req.payload.bit_offset[2:0];
            oor_reg      <= acc_oor;
            n_reg        <= n_sat;
            nbytes_reg   <= IW'(nbytes_sum >> 3);
            idx_reg      <= '0;
            ones_reg     <= '0;
            fset_reg     <= 1'b0;
            fclr_reg     <= 1'b0;
            lset_reg     <= n_sat;
            lclr_reg     <= n_sat;
        end
        if (state_reg == ST_RMW) begin
            prior_reg <= !oor_reg && (kind_reg != KIND_QUERY) &&
                         ((rd_byte_reg & bit_mask) != BYTE_ZERO);
        end
        if ((state_reg == ST_SCAN) && scan_issue) begin
            idx_reg      <= idx_reg + IW'(1);
            pend_idx_reg <= AW'(idx_reg);
        end
        if (pend_reg) begin
            ones_reg <= ones_reg + CNT_W'(pop8(rd_byte_reg));
            if (!fset_reg && (rd_byte_reg != BYTE_ZERO)) begin
                fset_reg <= 1'b1;
                if (pos_set < n_reg) begin
                    lset_reg <= pos_set;
                end
            end
            if (!fclr_reg && (rd_byte_reg != BYTE_ONES)) begin
                fclr_reg <= 1'b1;
                if (pos_clr < n_reg) begin
                    lclr_reg <= pos_clr;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_SCAN) && scan_end && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (rsp.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if ((state_reg == ST_SCAN) && scan_end && out_free) begin
            out_reg.bit_value    <= prior_reg;
            out_reg.out_of_range <= oor_reg;
            out_reg.ones_count   <= ones_reg;
            out_reg.any_set      <= (ones_reg != '0);
            out_reg.lowest_set   <= lset_reg;
            out_reg.lowest_clear <= lclr_reg;
        end
    end

endmodule

// ===== dv/tb_bitmap_set_find_count_top.sv =====
// Self-checking testbench for bitmap_set_find_count_top: directed and random requests
// against an in-bench bitmap predictor, under several sender and receiver idling patterns.
// Depends on bsfc_pkg, the channel interfaces in bsfc_if.sv and the top-level RTL.
module tb_bitmap_set_find_count_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfc_pkg::*;

    localparam int MAP_BITS = MAX_BITS_DEF;
    localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 150;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    bsfc_req_if req_bus ();
    bsfc_rsp_if rsp_bus ();

    // Predictor state: stored bytes and the bit count register.
    logic [7:0]       map_bytes [MAP_BYTES];
    logic [CNT_W-1:0] map_bit_count;
    rsp_t             pending_responses [$];

    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_seq;
    int unsigned hold_len;
    int unsigned cycle_count = 0;

    bitmap_set_find_count_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    // Free-running 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bitmap_set_find_count_top regression: fail");
            $finish;
        end
    end

    // Computes the response to one request and applies its effect on the bitmap.
    function automatic rsp_t predict_response(input req_t r);
        int unsigned n_used;
        int unsigned nbytes;
        int unsigned ones;
        int unsigned pos;
        bit          found_set;
        bit          found_clr;
        logic [7:0]  v;
        rsp_t        e;
        n_used = (map_bit_count > MAP_BITS) ? MAP_BITS : map_bit_count;
        nbytes = (n_used + 7) / 8;
        ones = 0;
        found_set = 1'b0;
        found_clr = 1'b0;
        e = '0;
        e.lowest_set = CNT_W'(n_used);
        e.lowest_clear = CNT_W'(n_used);
        // Single-bit access; out-of-range offsets leave the map alone.
        if (r.kind != KIND_QUERY)
        begin
            if (r.bit_offset >= n_used)
            begin
                e.out_of_range = 1'b1;
            end
            else
            begin
                e.bit_value = map_bytes[r.bit_offset / 8][r.bit_offset % 8];
                if (r.kind == KIND_SET)
                begin
                    map_bytes[r.bit_offset / 8][r.bit_offset % 8] = 1'b1;
                end
                else if (r.kind == KIND_CLR)
                begin
                    map_bytes[r.bit_offset / 8][r.bit_offset % 8] = 1'b0;
                end
            end
        end
        // Byte walk: padding bits count, but searches stop at the bit count.
        for (int i = 0; i < nbytes; i++)
        begin
            v = map_bytes[i];
            for (int k = 0; k < 8; k++)
            begin
                ones += v[k];
            end
            if (!found_set && v != BYTE_ZERO)
            begin
                found_set = 1'b1;
                pos = 8;
                for (int k = 7; k >= 0; k--)
                begin
                    if (v[k])
                    begin
                        pos = k;
                    end
                end
                if (i * 8 + pos < n_used)
                begin
                    e.lowest_set = CNT_W'(i * 8 + pos);
                end
            end
            if (!found_clr && v != BYTE_ONES)
            begin
                found_clr = 1'b1;
                pos = 8;
                for (int k = 7; k >= 0; k--)
                begin
                    if (!v[k])
                    begin
                        pos = k;
                    end
                end
                if (i * 8 + pos < n_used)
                begin
                    e.lowest_clear = CNT_W'(i * 8 + pos);
                end
            end
        end
        e.ones_count = CNT_W'(ones);
        e.any_set = (ones != 0);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin : response_checker
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = rsp_bus.payload;
            if (pending_responses.size() == 0)
            begin
                report_mismatch("response with no request pending", 1, 0);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (got.bit_value !== want.bit_value)
                    report_mismatch("bit_value", got.bit_value, want.bit_value);
                if (got.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
                if (got.ones_count !== want.ones_count)
                    report_mismatch("ones_count", got.ones_count, want.ones_count);
                if (got.any_set !== want.any_set)
                    report_mismatch("any_set", got.any_set, want.any_set);
                if (got.lowest_set !== want.lowest_set)
                    report_mismatch("lowest_set", got.lowest_set, want.lowest_set);
                if (got.lowest_clear !== want.lowest_clear)
                    report_mismatch("lowest_clear", got.lowest_clear, want.lowest_clear);
            end
        end
    end

    // Response ready: random stalls, or a long hold-off when one is requested.
    initial
    begin : rsp_ready_driver
        int unsigned hold_left;
        int unsigned seen_seq;
        hold_left = 0;
        seen_seq = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Offer one request, wait for it to be taken, then record its prediction.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [OFF_W-1:0] offset);
        req_t r;
        r.kind = kind;
        r.bit_offset = offset;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.payload <= r;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        pending_responses.push_back(predict_response(r));
    endtask

    // Write the bit count once the block has gone quiet.
    task automatic write_bit_count(input logic [CNT_W-1:0] value);
        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        map_bit_count = value;
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(input bit set_heavy);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return KIND_QUERY;
        else if (roll < 30)
            return KIND_GET;
        else if (roll < 80)
            return set_heavy ? KIND_SET : KIND_CLR;
        else
            return set_heavy ? KIND_CLR : KIND_SET;
    endfunction

    // The map is empty after reset with the full bit count in use.
    task automatic test_reset_state();
        send_request(KIND_QUERY, 10'd1023);
        send_request(KIND_GET, 10'd0);
    endtask

    // Get and set at both ends of the map and across a byte boundary, and clear at the low end.
    task automatic test_single_bits();
        write_bit_count(11'd1024);
        send_request(KIND_SET, 10'd0);
        send_request(KIND_SET, 10'd1023);
        send_request(KIND_GET, 10'd1023);
        send_request(KIND_SET, 10'd8);
        send_request(KIND_CLR, 10'd0);
        send_request(KIND_GET, 10'd0);
        send_request(KIND_QUERY, 10'd0);
    endtask

    // Offsets at and beyond the bit count, and a bit count of zero.
    task automatic test_range_limits();
        write_bit_count(11'd10);
        send_request(KIND_SET, 10'd10);
        send_request(KIND_SET, 10'd9);
        send_request(KIND_CLR, 10'd1023);
        write_bit_count(11'd0);
        send_request(KIND_GET, 10'd0);
        send_request(KIND_QUERY, 10'd5);
    endtask

    // Bit counts above the map size behave as the full map.
    task automatic test_saturation();
        write_bit_count(11'd2047);
        send_request(KIND_CLR, 10'd1023);
        send_request(KIND_QUERY, 10'd0);
        write_bit_count(11'd1025);
        send_request(KIND_SET, 10'd1023);
    endtask

    // Bits left set past a reduced bit count still count but are never found.
    task automatic test_padding_bits();
        write_bit_count(11'd16);
        send_request(KIND_SET, 10'd15);
        send_request(KIND_SET, 10'd14);
        write_bit_count(11'd13);
        send_request(KIND_QUERY, 10'd0);
        // One bit in use and set: no clear position below the bit count.
        write_bit_count(11'd1);
        send_request(KIND_SET, 10'd0);
    endtask

    // Hold the response side off long enough that the block stops taking requests.
    task automatic test_input_stall();
        write_bit_count(11'd64);
        set_idling(0, 0);
        hold_len = 600;
        hold_seq++;
        repeat (12)
        begin
            send_request(pick_kind(1'b1), OFF_W'($urandom_range(70)));
        end
    endtask

    // Random traffic in phases of bit count and idling; most counts are small.
    task automatic test_random_phases();
        int unsigned n_used;
        int unsigned items;
        int unsigned roll;
        logic [CNT_W-1:0] count;
        logic [OFF_W-1:0] offset;
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: set_idling(0, 0);
                1: set_idling(57, 0);
                2: set_idling(0, 57);
                default: set_idling(13, 13);
            endcase
            for (int slot = 0; slot < 4; slot++)
            begin
                case (slot)
                    0: count = CNT_W'($urandom_range(40, 1));
                    1: count = CNT_W'($urandom_range(200, 41));
                    2: count = mode[0] ? CNT_W'($urandom_range(2047, 1025)) : 11'd1024;
                    default: count = ($urandom_range(9) == 0) ? 11'd0
                                                              : CNT_W'($urandom_range(16, 1));
                endcase
                write_bit_count(count);
                n_used = (count > MAP_BITS) ? MAP_BITS : count;
                items = (n_used >= 512) ? 50 : 140;
                repeat (items)
                begin
                    roll = $urandom_range(99);
                    if (n_used == 0 || roll >= 95)
                        offset = OFF_W'($urandom);
                    else if (roll >= 85)
                        offset = OFF_W'(n_used - 1 + $urandom_range(2));
                    else
                        offset = OFF_W'($urandom_range(n_used - 1));
                    send_request(pick_kind(((mode + slot) % 2) == 0), offset);
                end
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        hold_seq = 0;
        hold_len = 0;
        set_idling(0, 0);
        foreach (map_bytes[i])
        begin
            map_bytes[i] = BYTE_ZERO;
        end
        map_bit_count = BIT_COUNT_RST;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        req_bus.valid <= 1'b0;
        req_bus.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_bits();
        test_range_limits();
        test_saturation();
        test_padding_bits();
        test_input_stall();
        test_random_phases();

        // Drain and let the block settle before the verdict.
        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("bitmap_set_find_count_top regression: pass");
        end
        else
        begin
            $display("bitmap_set_find_count_top regression: fail");
        end
        $finish;
    end

endmodule
